// File: hdl/ptt_pkg.sv
// ============================================================================
// ptt_pkg - shared types and constants of the periodic task timer table
// Holds the table geometry, the operation codes and the entry layout.
// ============================================================================
`default_nettype none

package ptt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths.
   localparam int ID_W   = 16;
   localparam int TICK_W = 16;
   localparam int OP_W   = 2;

   // Operation codes of a request beat.
   typedef enum logic [OP_W-1:0] {
      OP_SET      = 2'd0,
      OP_DELETE   = 2'd1,
      OP_TICK     = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   // One timer entry as stored in the table.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] delay;
      logic [TICK_W-1:0] period;
      logic              ready;
   } entry_type;

   // Results of the shared entry update unit.
   typedef struct packed {
      logic      match;
      entry_type ticked;
      entry_type retired;
   } alu_res_type;

endpackage

`default_nettype wire

// File: hdl/periodic_task_timer_table.sv
// ============================================================================
// periodic_task_timer_table - table of software timers with dispatch
// A small sequencer walks the entry table one slot at a time through a single
// entry update unit to set, delete, tick and dispatch timers.
// ============================================================================
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-----------------------------------
//   req     | in        | req_valid/req_stall| req_op, req_task_id, req_delay_ticks,
//           |           |                    | req_period_ticks
//   rsp     | out       | rsp_valid/rsp_stall| rsp_run_id, rsp_last
//
// A request is accepted while the sequencer idles; a tick needs nothing more. Set
// and delete read and examine each entry searched, then append or read and write
// the tail entry. Dispatch adds a read and update of each entry for a pending
// tick, a read of each entry scanned, tail moves and a flush (single table read port).
// Reset clears the count, the pending tick and control state, not the table.
// A stalled rsp beat holds the scan only at a further ready entry or at the end.
//
`default_nettype none

module periodic_task_timer_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ptt_pkg::OP_W-1:0]      req_op,
   input  wire logic [ptt_pkg::ID_W-1:0]      req_task_id,
   input  wire logic [ptt_pkg::TICK_W-1:0]    req_delay_ticks,
   input  wire logic [ptt_pkg::TICK_W-1:0]    req_period_ticks,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ptt_pkg::ID_W-1:0]           rsp_run_id,
   output logic                               rsp_last
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXAM,
      S_APPEND,
      S_MOVE_RD,
      S_MOVE_WR,
      S_FLUSH
   } state_type;

   // Sequencer and request registers.
   state_type                    state_ff,       state_in;
   ptt_pkg::op_type              op_ff,          op_in;
   logic [ptt_pkg::ID_W-1:0]     id_ff,          id_in;
   logic [ptt_pkg::TICK_W-1:0]   dly_ff,         dly_in;
   logic [ptt_pkg::TICK_W-1:0]   per_ff,         per_in;
   logic [ptt_pkg::CNT_W-1:0]    k_ff,           k_in;
   logic [ptt_pkg::CNT_W-1:0]    count_ff,       count_in;
   logic                         tick_pending_ff, tick_pending_in;
   logic                         tick_phase_ff,  tick_phase_in;
   logic                         hold_valid_ff,  hold_valid_in;
   logic [ptt_pkg::ID_W-1:0]     hold_id_ff,     hold_id_in;
   logic                         rsp_valid_ff,   rsp_valid_in;
   logic [ptt_pkg::ID_W-1:0]     rsp_run_id_ff,  rsp_run_id_in;
   logic                         rsp_last_ff,    rsp_last_in;

   // Entry table and its ports.
   ptt_pkg::entry_type           table_mem [ptt_pkg::TABLE_DEPTH];
   ptt_pkg::entry_type           rd_data_ff;
   logic [ptt_pkg::IDX_W-1:0]    rd_addr;
   logic                         wr_en;
   logic [ptt_pkg::IDX_W-1:0]    wr_addr;
   ptt_pkg::entry_type           wr_data;

   ptt_pkg::alu_res_type         alu_res;
   ptt_pkg::entry_type           new_entry;
   logic [ptt_pkg::CNT_W-1:0]    k_next;
   logic [ptt_pkg::CNT_W-1:0]    tail;
   logic [ptt_pkg::IDX_W-1:0]    k_idx;
   logic                         at_tail;
   logic                         out_free;
   ptt_pkg::op_type              req_op_cast;

   assign req_op_cast = ptt_pkg::op_type'(req_op);
   assign k_next      = k_ff + ptt_pkg::CNT_W'(1);
   assign tail        = count_ff - ptt_pkg::CNT_W'(1);
   assign k_idx       = k_ff[ptt_pkg::IDX_W-1:0];
   assign at_tail     = (k_next == count_ff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rd_addr     = (state_ff == S_MOVE_RD) ? tail[ptt_pkg::IDX_W-1:0] : k_idx;

   assign new_entry.id     = id_ff;
   assign new_entry.delay  = dly_ff;
   assign new_entry.period = per_ff;
   assign new_entry.ready  = 1'b0;

   // Shared compare and update unit for the entry under examination.
   ptt_entry_alu u_alu (
      .entry  (rd_data_ff),
      .key_id (id_ff),
      .res    (alu_res)
   );

   // Entry table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // Sequencer next-state and table write control.
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      id_in           = id_ff;
      dly_in          = dly_ff;
      per_in          = per_ff;
      k_in            = k_ff;
      count_in        = count_ff;
      tick_pending_in = tick_pending_ff;
      tick_phase_in   = tick_phase_ff;
      hold_valid_in   = hold_valid_ff;
      hold_id_in      = hold_id_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_run_id_in   = rsp_run_id_ff;
      rsp_last_in     = rsp_last_ff;
      wr_en           = 1'b0;
      wr_addr         = k_idx;
      wr_data         = new_entry;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_op_cast;
               id_in  = req_task_id;
               dly_in = req_delay_ticks;
               per_in = req_period_ticks;
               k_in   = '0;
               unique case (req_op_cast)
                  ptt_pkg::OP_SET: begin
                     if (req_task_id != '0) begin
                        state_in = (count_ff == '0) ? S_APPEND : S_READ;
                     end
                  end
                  ptt_pkg::OP_DELETE: begin
                     if (req_task_id != '0 && count_ff != '0) begin
                        state_in = S_READ;
                     end
                  end
                  ptt_pkg::OP_TICK: begin
                     tick_pending_in = 1'b1;
                  end
                  ptt_pkg::OP_DISPATCH: begin
                     tick_pending_in = 1'b0;
                     tick_phase_in   = tick_pending_ff;
                     if (count_ff != '0) begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_READ: begin
            state_in = S_EXAM;
         end

         S_EXAM: begin
            unique case (op_ff)
               ptt_pkg::OP_SET: begin
                  if (alu_res.match) begin
                     wr_en    = 1'b1;
                     state_in = S_IDLE;
                  end else if (at_tail) begin
                     state_in = S_APPEND;
                  end else begin
                     k_in     = k_next;
                     state_in = S_READ;
                  end
               end
               ptt_pkg::OP_DELETE: begin
                  if (alu_res.match) begin
                     if (at_tail) begin
                        count_in = tail;
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_MOVE_RD;
                     end
                  end else if (at_tail) begin
                     state_in = S_IDLE;
                  end else begin
                     k_in     = k_next;
                     state_in = S_READ;
                  end
               end
               ptt_pkg::OP_DISPATCH: begin
                  if (tick_phase_ff) begin
                     // Tick pass: ready on zero delay, else count down.
                     wr_en   = 1'b1;
                     wr_data = alu_res.ticked;
                     if (at_tail) begin
                        k_in          = '0;
                        tick_phase_in = 1'b0;
                     end else begin
                        k_in = k_next;
                     end
                     state_in = S_READ;
                  end else if (!rd_data_ff.ready) begin
                     k_in     = k_next;
                     state_in = at_tail ? S_FLUSH : S_READ;
                  end else if (!hold_valid_ff || out_free) begin
                     // Send the previous held beat and hold this one until
                     // it is known whether another follows.
                     if (hold_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_run_id_in = hold_id_ff;
                        rsp_last_in   = 1'b0;
                     end
                     hold_valid_in = 1'b1;
                     hold_id_in    = rd_data_ff.id;
                     if (rd_data_ff.period == '0) begin
                        if (at_tail) begin
                           count_in = tail;
                           state_in = S_FLUSH;
                        end else begin
                           state_in = S_MOVE_RD;
                        end
                     end else begin
                        wr_en    = 1'b1;
                        wr_data  = alu_res.retired;
                        k_in     = k_next;
                        state_in = at_tail ? S_FLUSH : S_READ;
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_APPEND: begin
            if (count_ff < ptt_pkg::CNT_W'(ptt_pkg::TABLE_DEPTH)) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[ptt_pkg::IDX_W-1:0];
               count_in = count_ff + ptt_pkg::CNT_W'(1);
            end
            state_in = S_IDLE;
         end

         S_MOVE_RD: begin
            state_in = S_MOVE_WR;
         end

         S_MOVE_WR: begin
            // The tail entry fills the freed slot; a dispatch skips it.
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            count_in = tail;
            if (op_ff == ptt_pkg::OP_DISPATCH) begin
               k_in     = k_next;
               state_in = (k_next < tail) ? S_READ : S_FLUSH;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_run_id_in = hold_id_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         tick_pending_ff <= 1'b0;
         tick_phase_ff   <= 1'b0;
         hold_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         k_ff            <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         tick_pending_ff <= tick_pending_in;
         tick_phase_ff   <= tick_phase_in;
         hold_valid_ff   <= hold_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         k_ff            <= k_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      dly_ff        <= dly_in;
      per_ff        <= per_in;
      hold_id_ff    <= hold_id_in;
      rsp_run_id_ff <= rsp_run_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_run_id = rsp_run_id_ff;
   assign rsp_last   = rsp_last_ff;

   // The entry count never exceeds the table.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ptt_pkg::CNT_W'(ptt_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // The scan index never passes the entry count.
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= count_ff)
      else $error("scan index beyond entry count");

   // No held beat survives the end of a dispatch.
   a_hold_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_valid_ff)
      else $error("held response beat left over while idle");

   // The entry count moves by at most one per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((count_ff == $past(count_ff)) ||
                         (count_ff == $past(count_ff) + ptt_pkg::CNT_W'(1)) ||
                         (count_ff + ptt_pkg::CNT_W'(1) == $past(count_ff))))
      else $error("entry count jumped");

endmodule

`default_nettype wire

// File: hdl/ptt_entry_alu.sv
// ============================================================================
// ptt_entry_alu - shared entry update unit
// Compares one entry's id against the request id and forms the entry after a
// tick and after the entry has been dispatched.
// ============================================================================
`default_nettype none

module ptt_entry_alu (
   input  wire ptt_pkg::entry_type      entry,
   input  wire logic [ptt_pkg::ID_W-1:0] key_id,
   output ptt_pkg::alu_res_type          res
);

   logic delay_zero;

   assign delay_zero = (entry.delay == '0);

   // Id compare, tick update and post-dispatch update share one delay check.
   always_comb begin
      res.match   = (entry.id == key_id);

      res.ticked  = entry;
      if (delay_zero) begin
         res.ticked.ready = 1'b1;
      end else begin
         res.ticked.delay = entry.delay - ptt_pkg::TICK_W'(1);
      end

      res.retired       = entry;
      res.retired.ready = 1'b0;
      if (delay_zero) begin
         res.retired.delay = entry.period - ptt_pkg::TICK_W'(1);
      end
   end

endmodule

`default_nettype wire

// File: test/periodic_task_timer_table_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// periodic_task_timer_table_tb - self-checking bench for the task timer table
// Runs directed and then random set, delete, tick and dispatch beats through
// the block. Every run beat is checked in order against a local timer model.
// Both channels idle at random.
// ============================================================================

module periodic_task_timer_table_tb;

   localparam int RAND_ITEMS   = 255;
   localparam int POOL_SIZE    = 12;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 500000;

   // One expected run beat.
   typedef struct packed {
      logic [ptt_pkg::ID_W-1:0] run_id;
      logic                     last;
   } run_beat_type;

   // One row of the directed script; a nonzero known_run is the single run
   // that the row must produce, read straight off the behavior.
   typedef struct {
      ptt_pkg::op_type            op;
      logic [ptt_pkg::ID_W-1:0]   id;
      logic [ptt_pkg::TICK_W-1:0] dly;
      logic [ptt_pkg::TICK_W-1:0] per;
      bit                         known;
      logic [ptt_pkg::ID_W-1:0]   known_run;
   } script_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [ptt_pkg::OP_W-1:0]     req_op = ptt_pkg::OP_SET;
   logic [ptt_pkg::ID_W-1:0]     req_task_id = '0;
   logic [ptt_pkg::TICK_W-1:0]   req_delay_ticks = '0;
   logic [ptt_pkg::TICK_W-1:0]   req_period_ticks = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [ptt_pkg::ID_W-1:0]     rsp_run_id;
   logic                         rsp_last;

   // Timer table as the bench expects it to be.
   logic [ptt_pkg::ID_W-1:0]     slot_id     [ptt_pkg::TABLE_DEPTH];
   logic [ptt_pkg::TICK_W-1:0]   slot_delay  [ptt_pkg::TABLE_DEPTH];
   logic [ptt_pkg::TICK_W-1:0]   slot_period [ptt_pkg::TABLE_DEPTH];
   bit                           slot_ready  [ptt_pkg::TABLE_DEPTH];
   int                           live_count = 0;
   bit                           tick_owed = 1'b0;

   run_beat_type                 due_runs[$];
   script_row_type               script[$];
   logic [ptt_pkg::ID_W-1:0]     id_pool[POOL_SIZE];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   int requests_sent = 0;
   int dispatches_sent = 0;
   int runs_predicted = 0;
   int runs_checked = 0;
   int full_table_sets = 0;

   periodic_task_timer_table dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_task_id      (req_task_id),
      .req_delay_ticks  (req_delay_ticks),
      .req_period_ticks (req_period_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_id       (rsp_run_id),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // Remove a slot by moving the tail entry into it.
   function automatic void drop_slot(int k);
      int tail;
      tail = live_count - 1;
      slot_id[k]     = slot_id[tail];
      slot_delay[k]  = slot_delay[tail];
      slot_period[k] = slot_period[tail];
      slot_ready[k]  = slot_ready[tail];
      live_count     = tail;
   endfunction

   // Update the expected table for one accepted beat and queue its runs.
   function automatic void timer_step(ptt_pkg::op_type op,
                                      logic [ptt_pkg::ID_W-1:0] id,
                                      logic [ptt_pkg::TICK_W-1:0] dly,
                                      logic [ptt_pkg::TICK_W-1:0] per);
      int           k;
      int           found;
      int           first_run;
      run_beat_type tail_run;
      found = -1;
      first_run = due_runs.size();
      case (op)
         ptt_pkg::OP_SET, ptt_pkg::OP_DELETE: begin
            if (id != '0) begin
               for (k = 0; k < live_count; k++)
                  if (found < 0 && slot_id[k] == id) found = k;
               if (op == ptt_pkg::OP_DELETE) begin
                  if (found >= 0) drop_slot(found);
               end else if (found >= 0) begin
                  slot_delay[found]  = dly;
                  slot_period[found] = per;
                  slot_ready[found]  = 1'b0;
               end else if (live_count < ptt_pkg::TABLE_DEPTH) begin
                  slot_id[live_count]     = id;
                  slot_delay[live_count]  = dly;
                  slot_period[live_count] = per;
                  slot_ready[live_count]  = 1'b0;
                  live_count++;
               end else begin
                  full_table_sets++;
               end
            end
         end
         ptt_pkg::OP_TICK: begin
            tick_owed = 1'b1;
         end
         default: begin
            dispatches_sent++;
            // A pending tick expires zero delays and counts the rest down.
            if (tick_owed) begin
               tick_owed = 1'b0;
               for (k = 0; k < live_count; k++)
                  if (slot_delay[k] == '0) slot_ready[k] = 1'b1;
                  else slot_delay[k] = slot_delay[k] - ptt_pkg::TICK_W'(1);
            end
            // Scan in index order; an entry moved into a freed slot waits.
            for (k = 0; k < live_count; k++) begin
               if (slot_ready[k]) begin
                  due_runs.push_back('{run_id: slot_id[k], last: 1'b0});
                  runs_predicted++;
                  if (slot_period[k] == '0) begin
                     drop_slot(k);
                  end else begin
                     slot_ready[k] = 1'b0;
                     if (slot_delay[k] == '0)
                        slot_delay[k] = slot_period[k] - ptt_pkg::TICK_W'(1);
                  end
               end
            end
            if (due_runs.size() > first_run) begin
               tail_run = due_runs.pop_back();
               tail_run.last = 1'b1;
               due_runs.push_back(tail_run);
            end
         end
      endcase
   endfunction

   // Drive one request beat, hold it until accepted, then predict it.
   task automatic send_request(ptt_pkg::op_type op, logic [ptt_pkg::ID_W-1:0] id,
                               logic [ptt_pkg::TICK_W-1:0] dly,
                               logic [ptt_pkg::TICK_W-1:0] per);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_task_id      <= id;
      req_delay_ticks  <= dly;
      req_period_ticks <= per;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      timer_step(op, id, dly, per);
      requests_sent++;
   endtask

   task automatic add_row(ptt_pkg::op_type op, logic [ptt_pkg::ID_W-1:0] id,
                          logic [ptt_pkg::TICK_W-1:0] dly,
                          logic [ptt_pkg::TICK_W-1:0] per, bit known,
                          logic [ptt_pkg::ID_W-1:0] known_run);
      script.push_back('{op, id, dly, per, known, known_run});
   endtask

   // Receiver stalls at random according to the current idle mix.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Compare every accepted run beat with the oldest expected one.
   always @(posedge clock) begin
      run_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_runs.size() == 0) begin
            $error("rsp_run_id: no run expected, got %h (last %b)", rsp_run_id, rsp_last);
            error_count++;
         end else begin
            want = due_runs.pop_front();
            if (rsp_run_id !== want.run_id) begin
               $error("rsp_run_id: expected %h, got %h", want.run_id, rsp_run_id);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %b, got %b", want.last, rsp_last);
               error_count++;
            end
            runs_checked++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d runs still expected",
                  cycle_count, due_runs.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int                         base;
      int                         n_rand;
      int                         pick;
      ptt_pkg::op_type            op;
      logic [ptt_pkg::ID_W-1:0]   id;
      logic [ptt_pkg::TICK_W-1:0] dly;
      logic [ptt_pkg::TICK_W-1:0] per;

      // Empty table, collapsed ticks, a one-shot, a full table, an update,
      // ignored deletes and the skip of an entry moved into a freed slot.
      add_row(ptt_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000);
      add_row(ptt_pkg::OP_TICK,     16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h0000, 16'h0005, 16'h0005, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_TICK,     16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_TICK,     16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF);
      add_row(ptt_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h0001, 16'h0000, 16'h0001, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h0002, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h0003, 16'h0001, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h0004, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h8005, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h0006, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h7FF7, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h0008, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h0009, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_SET,      16'h0002, 16'h0000, 16'hFFFF, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_DELETE,   16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_DELETE,   16'h1234, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_TICK,     16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);
      add_row(ptt_pkg::OP_DELETE,   16'h0001, 16'h0000, 16'h0000, 1'b0, 16'h0000);

      // Small ids that sets and deletes keep hitting, plus a few wide ones.
      for (int k = 0; k < POOL_SIZE; k++)
         id_pool[k] = (k < 6) ? ptt_pkg::ID_W'(k + 1)
                              : ptt_pkg::ID_W'($urandom_range(1, 65535));

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Sender idles lightly while the receiver stalls heavily.
      send_idle_pct = 16;
      recv_idle_pct = 87;

      foreach (script[r]) begin
         base = runs_predicted;
         send_request(script[r].op, script[r].id, script[r].dly, script[r].per);
         if (script[r].known) begin
            // Put the value known by hand in place of what the model queued
            // for this row; earlier runs still waiting stay in the queue.
            repeat (runs_predicted - base) void'(due_runs.pop_back());
            if (script[r].known_run != '0)
               due_runs.push_back('{run_id: script[r].known_run, last: 1'b1});
         end
      end

      // Random part: mostly well-formed traffic on a small id pool, with
      // zero ids, wide ids and long delays mixed in.
      n_rand = 0;
      while (n_rand < RAND_ITEMS) begin
         if (n_rand == RAND_ITEMS / 3) begin
            send_idle_pct = 87;
            recv_idle_pct = 16;
         end else if (n_rand == 2 * RAND_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) op = ptt_pkg::OP_SET;
         else if (pick < 45) op = ptt_pkg::OP_DELETE;
         else if (pick < 70) op = ptt_pkg::OP_TICK;
         else op = ptt_pkg::OP_DISPATCH;
         pick = $urandom_range(0, 19);
         if (pick == 0) id = '0;
         else if (pick == 1) id = ptt_pkg::ID_W'($urandom_range(0, 65535));
         else id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
         dly = ($urandom_range(0, 9) == 0) ? ptt_pkg::TICK_W'($urandom_range(0, 65535))
                                           : ptt_pkg::TICK_W'($urandom_range(0, 3));
         pick = $urandom_range(0, 19);
         if (pick < 5) per = '0;
         else if (pick < 18) per = ptt_pkg::TICK_W'($urandom_range(1, 4));
         else per = ptt_pkg::TICK_W'($urandom_range(0, 65535));
         send_request(op, id, dly, per);
         n_rand++;
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // Let every expected run arrive, then watch for stray beats.
      while (due_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests including %0d dispatches; checked %0d task runs.",
               requests_sent, dispatches_sent, runs_checked);
      $display("Sets refused by a full table: %0d; cycles used: %0d.",
               full_table_sets, cycle_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
